// ----- sv/m4au_pkg.sv -----
// Shared types and codes for the fixed-point matrix arithmetic unit.
package m4au_pkg;

  // Operation codes carried in the input sideband
  typedef enum logic [2:0] {
    OP_ADD       = 3'd0,
    OP_SUB       = 3'd1,
    OP_MUL       = 3'd2,
    OP_SCALE_MUL = 3'd3,
    OP_SCALE_DIV = 3'd4
  } op_e;

  // Sequencer states
  typedef enum logic [3:0] {
    S_LOAD,
    S_RD,
    S_LATCH,
    S_EXEC,
    S_ACC,
    S_RND,
    S_DIV,
    S_DSGN,
    S_OUT
  } state_e;

endpackage

// ----- sv/matrix4x4_arith_unit.sv -----
// Top level: sequenced fixed-point matrix add, subtract, product, scale and divide.
//
// The unit loads DIM*DIM beats of A and B elements (row-major, one beat per cycle)
// into two RAMs; the operation and scalar are sampled on the final beat. It then
// computes and emits DIM*DIM result beats in row-major order, with tlast on the
// final one, and accepts no input until that beat is taken. Every element goes
// through one shared datapath: a RAM read and operand latch (S_RD, S_LATCH), then
// add/subtract, a zero divisor or an undefined operation in S_EXEC alone, scale
// multiply in S_EXEC, S_ACC and S_RND through the single 32x32 multiplier and the
// accumulator, and scale divide in set-up, one restoring step per quotient bit and
// sign fix-up (S_EXEC, S_DIV, S_DSGN). The matrix product repeats read, multiply
// and accumulate for each term and then rounds. Each result then waits in the
// output register until it is taken. Products are rounded to nearest with ties
// upward, quotients to nearest with ties away from zero; results saturate and flag
// overflow. The stores need no clearing after reset.
module matrix4x4_arith_unit #(
  parameter int DIM       = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,  // element_a[31:0], element_b[63:32], scalar[95:64]
  input  logic [2:0]   s_axis_tuser,  // operation[2:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [39:0]  m_axis_tdata,  // result_element[31:0], row[33:32], column[35:34]
  output logic         m_axis_tlast,
  output logic [1:0]   m_axis_tuser   // overflow[0], divide_by_zero[1]
);

  import m4au_pkg::*;

  localparam int CELLS = DIM * DIM;
  localparam int IDX_W = $clog2(CELLS);
  localparam int K_W   = $clog2(DIM);
  localparam int ACC_W = 64 + $clog2(DIM) + 1;
  localparam int NUM_W = 32 + FRAC_BITS + 1;
  localparam int CNT_W = $clog2(NUM_W + 1);

  localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  state_e state_q, state_d;

  logic [IDX_W-1:0] load_q, idx_q, rbase_q, kbase_q;
  logic [K_W-1:0]   r_q, c_q, k_q;
  logic [2:0]       op_q;
  logic signed [31:0] scal_q, a_q, b_q;
  logic signed [63:0] prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [31:0]      den_q;
  logic [32:0]      rem_q;
  logic [NUM_W-1:0] num_q;
  logic             neg_q;
  logic [CNT_W-1:0] cnt_q;
  logic [31:0]      res_q;
  logic             ovf_q, dz_q;

  logic             in_acc, out_acc;
  logic [IDX_W-1:0] raddr_a, raddr_b;
  logic [31:0]      rd_a, rd_b;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Element stores
  always_comb begin
    if (op_q == OP_MUL) begin
      raddr_a = rbase_q + IDX_W'(k_q);
      raddr_b = kbase_q + IDX_W'(c_q);
    end else begin
      raddr_a = idx_q;
      raddr_b = idx_q;
    end
  end

  m4au_ram #(.WIDTH(32), .DEPTH(CELLS)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (load_q),
    .wdata_i (s_axis_tdata[31:0]),
    .raddr_i (raddr_a),
    .rdata_o (rd_a)
  );

  m4au_ram #(.WIDTH(32), .DEPTH(CELLS)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (load_q),
    .wdata_i (s_axis_tdata[63:32]),
    .raddr_i (raddr_b),
    .rdata_o (rd_b)
  );

  // Shared arithmetic: add/sub, rounding, divider step, magnitudes
  logic signed [32:0]      sum33;
  logic signed [ACC_W-1:0] rnd;
  logic [32:0]             rem_sh;
  logic                    qbit;
  logic [31:0]             amag, smag;

  always_comb begin
    if (op_q == OP_SUB) begin
      sum33 = {a_q[31], a_q} - {b_q[31], b_q};
    end else begin
      sum33 = {a_q[31], a_q} + {b_q[31], b_q};
    end
    rnd    = (acc_q + (ACC_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    rem_sh = {rem_q[31:0], num_q[NUM_W-1]};
    qbit   = (rem_sh >= {1'b0, den_q});
    amag   = a_q[31] ? 32'(-a_q) : a_q;
    smag   = scal_q[31] ? 32'(-scal_q) : scal_q;
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    unique case (state_q)
      S_LOAD: begin
        s_axis_tready = 1'b1;
        if (in_acc && load_q == IDX_W'(CELLS - 1)) begin
          state_d = S_RD;
        end
      end
      S_RD:    state_d = S_LATCH;
      S_LATCH: state_d = S_EXEC;
      S_EXEC: begin
        if (op_q == OP_MUL || op_q == OP_SCALE_MUL) begin
          state_d = S_ACC;
        end else if (op_q == OP_SCALE_DIV && scal_q != 32'sd0) begin
          state_d = S_DIV;
        end else begin
          state_d = S_OUT;
        end
      end
      S_ACC: begin
        if (op_q == OP_MUL && k_q != K_W'(DIM - 1)) begin
          state_d = S_RD;
        end else begin
          state_d = S_RND;
        end
      end
      S_RND: state_d = S_OUT;
      S_DIV: begin
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          state_d = S_DSGN;
        end
      end
      S_DSGN: state_d = S_OUT;
      S_OUT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          state_d = (idx_q == IDX_W'(CELLS - 1)) ? S_LOAD : S_RD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  // Control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q  <= '0;
      idx_q   <= '0;
      r_q     <= '0;
      c_q     <= '0;
      k_q     <= '0;
      rbase_q <= '0;
      kbase_q <= '0;
      cnt_q   <= '0;
    end else begin
      if (in_acc) begin
        load_q <= (load_q == IDX_W'(CELLS - 1)) ? '0 : load_q + 1'b1;
        idx_q   <= '0;
        r_q     <= '0;
        c_q     <= '0;
        k_q     <= '0;
        rbase_q <= '0;
        kbase_q <= '0;
      end
      if (state_q == S_ACC && op_q == OP_MUL && k_q != K_W'(DIM - 1)) begin
        k_q     <= k_q + 1'b1;
        kbase_q <= kbase_q + IDX_W'(DIM);
      end
      if (state_q == S_EXEC) begin
        cnt_q <= '0;
      end else if (state_q == S_DIV) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (state_q == S_OUT && out_acc) begin
        idx_q   <= idx_q + 1'b1;
        k_q     <= '0;
        kbase_q <= '0;
        if (c_q == K_W'(DIM - 1)) begin
          c_q     <= '0;
          r_q     <= r_q + 1'b1;
          rbase_q <= rbase_q + IDX_W'(DIM);
        end else begin
          c_q <= c_q + 1'b1;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      scal_q <= s_axis_tdata[95:64];
      op_q   <= s_axis_tuser;
      acc_q  <= '0;
    end
    case (state_q)
      S_LATCH: begin
        a_q <= rd_a;
        b_q <= rd_b;
      end
      S_EXEC: begin
        prod_q <= a_q * ((op_q == OP_MUL) ? b_q : scal_q);
        num_q  <= (NUM_W'(amag) << FRAC_BITS) + NUM_W'(smag >> 1);
        den_q  <= smag;
        rem_q  <= '0;
        neg_q  <= a_q[31] ^ scal_q[31];
        case (op_q) inside
          OP_ADD, OP_SUB: begin
            dz_q <= 1'b0;
            if (sum33[32] != sum33[31]) begin
              res_q <= sum33[32] ? SAT_MIN : SAT_MAX;
              ovf_q <= 1'b1;
            end else begin
              res_q <= sum33[31:0];
              ovf_q <= 1'b0;
            end
          end
          OP_SCALE_DIV: begin
            // Zero divisor: saturate by the sign of A
            ovf_q <= 1'b0;
            dz_q  <= (scal_q == 32'sd0);
            if (scal_q == 32'sd0 && a_q > 32'sd0) begin
              res_q <= SAT_MAX;
            end else if (scal_q == 32'sd0 && a_q < 32'sd0) begin
              res_q <= SAT_MIN;
            end else begin
              res_q <= '0;
            end
          end
          default: begin
            res_q <= '0;
            ovf_q <= 1'b0;
            dz_q  <= 1'b0;
          end
        endcase
      end
      S_ACC: acc_q <= acc_q + ACC_W'(prod_q);
      S_RND: begin
        if (!(&rnd[ACC_W-1:31] || ~|rnd[ACC_W-1:31])) begin
          res_q <= rnd[ACC_W-1] ? SAT_MIN : SAT_MAX;
          ovf_q <= 1'b1;
        end else begin
          res_q <= rnd[31:0];
        end
      end
      S_DIV: begin
        rem_q <= qbit ? (rem_sh - {1'b0, den_q}) : rem_sh;
        num_q <= {num_q[NUM_W-2:0], qbit};
      end
      S_DSGN: begin
        if (!neg_q && |num_q[NUM_W-1:31]) begin
          res_q <= SAT_MAX;
          ovf_q <= 1'b1;
        end else if (neg_q && (|num_q[NUM_W-1:32] || (num_q[31] && |num_q[30:0]))) begin
          res_q <= SAT_MIN;
          ovf_q <= 1'b1;
        end else begin
          res_q <= neg_q ? 32'(-num_q[31:0]) : num_q[31:0];
        end
      end
      S_OUT: begin
        if (out_acc) begin
          acc_q <= '0;
        end
      end
      default: ;
    endcase
  end

  // Result beat
  assign m_axis_tdata = {4'b0000, 2'(c_q), 2'(r_q), res_q};
  assign m_axis_tlast = (idx_q == IDX_W'(CELLS - 1));
  assign m_axis_tuser = {dz_q, ovf_q};

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input accepted while a result is pending");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (r_q == K_W'(DIM - 1) && c_q == K_W'(DIM - 1)))
    else $error("tlast away from final element");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(ovf_q && dz_q))
    else $error("overflow and divide by zero together");

  a_dz_only_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && dz_q) |-> (op_q == OP_SCALE_DIV && scal_q == 32'sd0))
    else $error("divide by zero flag without zero divisor");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_LOAD) |-> (load_q == '0))
    else $error("load count not cleared during compute");
`endif

endmodule

// ----- sv/m4au_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module m4au_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the fixed-point matrix arithmetic unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import m4au_pkg::*;

  localparam int CELLS = 16;
  localparam longint MAXV = 64'sd2147483647;
  localparam longint MINV = -64'sd2147483648;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [31:0] elem;
    logic [1:0]  row;
    logic [1:0]  col;
    logic        last;
    logic        ovf;
    logic        dz;
  } elem_res_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [39:0]  m_axis_tdata;
  logic         m_axis_tlast;
  logic [1:0]   m_axis_tuser;

  matrix4x4_arith_unit DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: loaded elements and load position
  logic signed [31:0] a_mat [CELLS];
  logic signed [31:0] b_mat [CELLS];
  int load_pos = 0;
  elem_res_t expected_q [$];
  int errors = 0;
  int matrices_done = 0;
  int results_seen = 0;
  int ovf_seen = 0;
  int dz_seen = 0;
  int cycles = 0;
  bit hold_rx = 1'b0;

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, results_seen);
    errors++;
  endtask

  function automatic longint sat(input longint v, inout bit ovf);
    if (v > MAXV) begin ovf = 1; return MAXV; end
    if (v < MINV) begin ovf = 1; return MINV; end
    return v;
  endfunction

  // Exact product sum, rounded to nearest with ties upward
  function automatic longint round_prod(input longint hi, input longint lo);
    return hi + ((lo + 64'sd32768) >>> 16);
  endfunction

  function automatic longint quotient(input longint a, input longint s, inout bit ovf);
    longint n, un, ud, q;
    n = a * 65536;
    un = n < 0 ? -n : n;
    ud = s < 0 ? -s : s;
    q = (un + ud / 2) / ud;
    return sat(((n < 0) != (s < 0)) ? -q : q, ovf);
  endfunction

  // Load one beat; on the sixteenth compute the whole result matrix
  task automatic predict_beat(input logic [95:0] d, input logic [2:0] op);
    longint hi, lo, p, v, s;
    bit ovf, dz;
    int r, c;
    a_mat[load_pos] = d[31:0];
    b_mat[load_pos] = d[63:32];
    if (load_pos < CELLS - 1) begin
      load_pos++;
      return;
    end
    load_pos = 0;
    s = $signed(d[95:64]);
    for (int i = 0; i < CELLS; i++) begin
      ovf = 0; dz = 0; v = 0; hi = 0; lo = 0;
      r = i / 4; c = i % 4;
      case (op)
        OP_ADD: v = sat(longint'(a_mat[i]) + b_mat[i], ovf);
        OP_SUB: v = sat(longint'(a_mat[i]) - b_mat[i], ovf);
        OP_MUL: begin
          for (int k = 0; k < 4; k++) begin
            p = longint'(a_mat[r*4+k]) * b_mat[k*4+c];
            hi += p >>> 16;
            lo += p & 64'hFFFF;
          end
          v = sat(round_prod(hi, lo), ovf);
        end
        OP_SCALE_MUL: begin
          p = longint'(a_mat[i]) * s;
          v = sat(round_prod(p >>> 16, p & 64'hFFFF), ovf);
        end
        OP_SCALE_DIV: begin
          if (s == 0) begin
            dz = 1;
            v = a_mat[i] > 0 ? MAXV : (a_mat[i] < 0 ? MINV : 0);
          end else v = quotient(a_mat[i], s, ovf);
        end
        default: v = 0;
      endcase
      expected_q.push_back('{v[31:0], r[1:0], c[1:0], i == CELLS-1, ovf, dz});
    end
    matrices_done++;
  endtask

  // Cycle limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("matrix4x4_arith_unit test failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_rx) m_axis_tready <= 1'b0;
      else if ($urandom_range(0, 99) < 8) m_axis_tready <= 1'b0;
      else if ($urandom_range(0, 99) < 3) m_axis_tready <= 1'b0;
      else m_axis_tready <= 1'b1;
    end
  end

  // Check each accepted result beat against the oldest expectation
  always @(posedge clk_i) begin
    elem_res_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        report("unexpected beat", m_axis_tdata[31:0], 0);
      end else begin
        w = expected_q.pop_front();
        if (m_axis_tdata[31:0] !== w.elem)
          report("element", $signed(m_axis_tdata[31:0]), $signed(w.elem));
        if (m_axis_tdata[33:32] !== w.row) report("row", m_axis_tdata[33:32], w.row);
        if (m_axis_tdata[35:34] !== w.col) report("column", m_axis_tdata[35:34], w.col);
        if (m_axis_tdata[39:36] !== 4'd0) report("pad", m_axis_tdata[39:36], 0);
        if (m_axis_tlast !== w.last) report("last", m_axis_tlast, w.last);
        if (m_axis_tuser[0] !== w.ovf) report("overflow", m_axis_tuser[0], w.ovf);
        if (m_axis_tuser[1] !== w.dz) report("div zero", m_axis_tuser[1], w.dz);
        if (w.ovf) ovf_seen++;
        if (w.dz) dz_seen++;
      end
    end
  end

  // Send one beat with a random gap before it; valid stays high afterwards
  task automatic send_beat(input logic [31:0] ea, input logic [31:0] eb,
                           input logic [31:0] sc, input logic [2:0] op, input bit gaps);
    int g;
    g = 0;
    if (gaps) g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
                  ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {sc, eb, ea};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_beat({sc, eb, ea}, op);
  endtask

  // Drop valid before the sender pauses
  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_elem(input int kind);
    case (kind)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
    endcase
  endfunction

  function automatic logic [2:0] rand_op();
    int x;
    x = $urandom_range(0, 19);
    if (x < 19) return 3'(x % 5);
    return 3'($urandom_range(5, 7));
  endfunction

  // Directed rows: fill value for A and B, scalar and operation per matrix
  typedef struct {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] sc;
    logic [2:0]  op;
    logic [31:0] want;
    bit          ovf;
    bit          dz;
    bit          known;
  } row_t;

  row_t table_rows [] = '{
    '{32'h7FFF_FFFF, 32'h0000_0001, 32'h0, OP_ADD, 32'h7FFF_FFFF, 1, 0, 1},
    '{32'h8000_0000, 32'h8000_0000, 32'h0, OP_MUL, 32'h7FFF_FFFF, 1, 0, 1},
    '{32'hFFFF_FFFF, 32'h0, 32'h0000_8000, OP_SCALE_MUL, 32'h0, 0, 0, 1},
    '{32'h0001_0000, 32'h0, 32'h0, OP_SCALE_DIV, 32'h7FFF_FFFF, 0, 1, 1},
    '{32'h1234_5678, 32'h9ABC_DEF0, 32'h0, 3'd6, 32'h0, 0, 0, 1}
  };

  initial begin
    int n_rand;
    row_t t;
    logic [31:0] sc;
    logic [2:0] op;
    int kind;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: each known row is checked here as well as by the predictor
    foreach (table_rows[i]) begin
      t = table_rows[i];
      for (int j = 0; j < CELLS; j++)
        send_beat(t.a, t.b, (j == CELLS-1) ? t.sc : ~t.sc, (j == CELLS-1) ? t.op : ~t.op, 0);
      if (t.known)
        foreach (expected_q[k])
          if (k >= expected_q.size() - CELLS &&
              (expected_q[k].elem !== t.want || expected_q[k].ovf !== t.ovf ||
               expected_q[k].dz !== t.dz))
            report("table row", i, k);
      if (i == 3) begin
        stop_sending();
        wait (expected_q.size() == 0);
      end
    end

    // Long receiver hold-off while the sender keeps going
    hold_rx = 1'b1;
    fork
      begin repeat (600) @(posedge clk_i); hold_rx = 1'b0; end
    join_none

    // Random matrices, mostly well-formed content with occasional extremes
    n_rand = 0;
    while (n_rand < 3) begin
      kind = $urandom_range(0, 3);
      op = (n_rand == 0) ? OP_SCALE_DIV : ((n_rand == 1) ? OP_SUB : rand_op());
      sc = $urandom_range(0, 5) == 0 ? 32'h0 : rand_elem($urandom_range(0, 3));
      for (int j = 0; j < CELLS; j++)
        send_beat(rand_elem(kind), rand_elem(kind), (j == CELLS-1) ? sc : $urandom(),
                  (j == CELLS-1) ? op : 3'($urandom()), 1);
      n_rand++;
      if (n_rand == 2) begin
        stop_sending();
        wait (expected_q.size() == 0);
      end
    end

    stop_sending();
    wait (expected_q.size() == 0);
    repeat (100) @(posedge clk_i);
    $display("Covered %0d matrices, %0d result beats (%0d saturated, %0d divide by zero).",
             matrices_done, results_seen, ovf_seen, dz_seen);
    if (errors == 0 && load_pos == 0) $display("matrix4x4_arith_unit test passed");
    else $display("matrix4x4_arith_unit test failed");
    $finish;
  end
endmodule
